// ===== sv/minibatch_kmeans_classifier_unit_macros.svh =====
// Assertion macros used by the checker of the k-means unit.
`ifndef MINIBATCH_KMEANS_CLASSIFIER_UNIT_MACROS_SVH
`define MINIBATCH_KMEANS_CLASSIFIER_UNIT_MACROS_SVH

// Checked only outside reset.
`define MKC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("k-means unit assertion failed");

// Also checked across reset.
`define MKC_ASSERT_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("k-means unit reset assertion failed");

`endif

// ===== sv/mkc_pkg.sv =====
package mkc_pkg;
  localparam int CFG_IDX_W = 3;
  localparam int DATA_W    = 32;
  localparam int ACC_W     = 73;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BATCH_LENGTH = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_RATE    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NORM_LMA     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_RATE  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LMA   = 3'd5;
endpackage

// ===== sv/minibatch_kmeans_classifier_unit.sv =====
// Mini-batch k-means classifier over two features (rate, logical address).
// Input channel in_valid/in_ready carries rate_raw and lma_raw; output
// channel out_valid/out_ready returns cluster_index, one beat per input beat.
// Config channel cfg_valid/cfg_ready (always ready) writes register cfg_index.
// One input is worked at a time; in_ready is low until its result is
// registered. Every divide (feature normalize, mean init, mean update) runs
// on one shared restoring divider, one quotient bit per cycle.
// Each point: normalize both features, then per centroid in use one 32x32
// square then one weight product per feature, then compare, then push into
// the buffer. When the buffer holds batch_length points, a batch update
// runs for each buffered point (count, rate divide, lma divide).
// The result waits in an output register; a stalled receiver only holds the
// block at the end of the next point.
// Reset, and any write of num_clusters, starts a sweep that sets every mean
// and count with in_ready low; config writes are still taken, and a
// num_clusters write restarts the sweep.
module minibatch_kmeans_classifier_unit #(
  parameter int MAX_CLUSTERS = 16,
  parameter int MAX_BATCH    = 8,
  parameter int FRAC_BITS    = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [31:0]                     rate_raw,
  input  logic [31:0]                     lma_raw,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [3:0]                      cluster_index,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mkc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mkc_pkg::DATA_W-1:0]      cfg_data
);
  import mkc_pkg::*;

  localparam int CIW = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int CW  = $clog2(MAX_CLUSTERS + 1);
  localparam int PIW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;
  localparam int FW  = $clog2(MAX_BATCH + 1);

  localparam logic [3:0] S_INIT_DIV = 4'd0;
  localparam logic [3:0] S_INIT_WR  = 4'd1;
  localparam logic [3:0] S_IDLE     = 4'd2;
  localparam logic [3:0] S_NORM_L   = 4'd3;
  localparam logic [3:0] S_NORM_END = 4'd4;
  localparam logic [3:0] S_SQ_R     = 4'd5;
  localparam logic [3:0] S_W_R      = 4'd6;
  localparam logic [3:0] S_SQ_L     = 4'd7;
  localparam logic [3:0] S_W_L      = 4'd8;
  localparam logic [3:0] S_CMP      = 4'd9;
  localparam logic [3:0] S_PUSH     = 4'd10;
  localparam logic [3:0] S_B_SEL    = 4'd11;
  localparam logic [3:0] S_B_CNT    = 4'd12;
  localparam logic [3:0] S_B_RATE   = 4'd13;
  localparam logic [3:0] S_B_LMA    = 4'd14;
  localparam logic [3:0] S_DIV      = 4'd15;

  // config
  logic [4:0]  nc;
  logic [3:0]  bl;
  logic [31:0] norm_rate, norm_lma;
  logic [7:0]  wr, wl;

  // state
  logic [31:0] mean_rate [MAX_CLUSTERS];
  logic [31:0] mean_lma  [MAX_CLUSTERS];
  logic [31:0] member_count [MAX_CLUSTERS];
  logic [31:0] pending_rate [MAX_BATCH];
  logic [31:0] pending_lma  [MAX_BATCH];
  logic [CIW-1:0] pending_cluster [MAX_BATCH];
  logic [FW-1:0]  pending_fill;

  logic [3:0]  state, ret;
  logic        done_pend;
  logic [CW-1:0]  ci;
  logic [FW-1:0]  bj;
  logic [CIW-1:0] k;
  logic [31:0] lma_in, xr, xl;
  logic [63:0] sq;
  logic [ACC_W-1:0] acc, best;
  logic [CIW-1:0] best_idx;
  logic        neg;

  // shared divider
  logic [31:0] rem, dq, den;
  logic [5:0]  dcnt;
  logic [32:0] dsh, ddiff;

  logic [CIW-1:0] raddr;
  logic [31:0] m_rate, m_lma, cnt_cur, cnt_inc, d_abs, mag_r, mag_l;
  logic [FW-1:0] fill_next;
  logic        batch_phase;

  assign in_ready  = (state == S_IDLE) && !done_pend;
  assign cfg_ready = 1'b1;

  assign batch_phase = (state == S_B_CNT) || (state == S_B_RATE) || (state == S_B_LMA) ||
                       ((state == S_DIV) && ((ret == S_B_RATE) || (ret == S_B_LMA)));
  assign raddr  = batch_phase ? k : ci[CIW-1:0];
  assign m_rate = mean_rate[raddr];
  assign m_lma  = mean_lma[raddr];
  assign cnt_cur = member_count[raddr];
  assign cnt_inc = (cnt_cur == 32'hFFFF_FFFF) ? cnt_cur : cnt_cur + 32'd1;

  assign dsh   = {rem, dq[31]};
  assign ddiff = dsh - {1'b0, den};

  always_comb begin
    d_abs = 32'd0;
    unique case (state)
      S_SQ_R:  d_abs = (xr > m_rate) ? xr - m_rate : m_rate - xr;
      S_SQ_L:  d_abs = (xl > m_lma) ? xl - m_lma : m_lma - xl;
      default: d_abs = 32'd0;
    endcase
  end

  assign mag_r = (pending_rate[bj[PIW-1:0]] >= m_rate) ? pending_rate[bj[PIW-1:0]] - m_rate
                                                        : m_rate - pending_rate[bj[PIW-1:0]];
  assign mag_l = (pending_lma[bj[PIW-1:0]] >= m_lma) ? pending_lma[bj[PIW-1:0]] - m_lma
                                                      : m_lma - pending_lma[bj[PIW-1:0]];
  assign fill_next = (32'(pending_fill) < MAX_BATCH) ? pending_fill + FW'(1) : pending_fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      nc           <= 5'(MAX_CLUSTERS > 16 ? 16 : MAX_CLUSTERS);
      bl           <= 4'(MAX_BATCH > 6 ? 6 : MAX_BATCH);
      norm_rate    <= 32'd1;
      norm_lma     <= 32'd1;
      wr           <= 8'd10;
      wl           <= 8'd0;
      state        <= S_INIT_DIV;
      ret          <= S_IDLE;
      ci           <= '0;
      bj           <= '0;
      pending_fill <= '0;
      out_valid    <= 1'b0;
      done_pend    <= 1'b0;
      dcnt         <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (done_pend && (!out_valid || out_ready)) begin
        out_valid     <= 1'b1;
        cluster_index <= 4'(best_idx);
        done_pend     <= 1'b0;
      end

      unique case (state)
        S_INIT_DIV: begin
          dq    <= 32'(ci) << FRAC_BITS;
          rem   <= '0;
          den   <= 32'(nc);
          dcnt  <= 6'd32;
          ret   <= S_INIT_WR;
          state <= S_DIV;
        end
        S_INIT_WR: begin
          mean_rate[ci[CIW-1:0]]    <= dq;
          mean_lma[ci[CIW-1:0]]     <= '0;
          member_count[ci[CIW-1:0]] <= '0;
          if (32'(ci) == MAX_CLUSTERS - 1) begin
            state <= S_IDLE;
          end else begin
            ci    <= ci + CW'(1);
            state <= S_INIT_DIV;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            lma_in <= lma_raw;
            dq     <= rate_raw;
            rem    <= '0;
            den    <= (norm_rate == 32'd0) ? 32'd1 : norm_rate;
            dcnt   <= 6'd32;
            ret    <= S_NORM_L;
            state  <= S_DIV;
          end
        end
        S_NORM_L: begin
          xr    <= dq;
          dq    <= lma_in;
          rem   <= '0;
          den   <= (norm_lma == 32'd0) ? 32'd1 : norm_lma;
          dcnt  <= 6'd32;
          ret   <= S_NORM_END;
          state <= S_DIV;
        end
        S_NORM_END: begin
          xl    <= dq;
          ci    <= '0;
          state <= S_SQ_R;
        end
        S_SQ_R: begin
          sq    <= 64'(d_abs) * 64'(d_abs);
          state <= S_W_R;
        end
        S_W_R: begin
          acc   <= ACC_W'(sq) * ACC_W'(wr);
          state <= S_SQ_L;
        end
        S_SQ_L: begin
          sq    <= 64'(d_abs) * 64'(d_abs);
          state <= S_W_L;
        end
        S_W_L: begin
          acc   <= acc + ACC_W'(sq) * ACC_W'(wl);
          state <= S_CMP;
        end
        S_CMP: begin
          if ((ci == '0) || (acc < best)) begin
            best     <= acc;
            best_idx <= ci[CIW-1:0];
          end
          if (ci + CW'(1) == CW'(nc)) begin
            state <= S_PUSH;
          end else begin
            ci    <= ci + CW'(1);
            state <= S_SQ_R;
          end
        end
        S_PUSH: begin
          if (32'(pending_fill) < MAX_BATCH) begin
            pending_rate[pending_fill[PIW-1:0]]    <= xr;
            pending_lma[pending_fill[PIW-1:0]]     <= xl;
            pending_cluster[pending_fill[PIW-1:0]] <= best_idx;
          end
          pending_fill <= fill_next;
          bj           <= '0;
          if (32'(fill_next) >= 32'(bl)) begin
            state <= S_B_SEL;
          end else begin
            done_pend <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_B_SEL: begin
          k     <= pending_cluster[bj[PIW-1:0]];
          state <= S_B_CNT;
        end
        S_B_CNT: begin
          member_count[k] <= cnt_inc;
          neg   <= pending_rate[bj[PIW-1:0]] < m_rate;
          dq    <= mag_r;
          rem   <= '0;
          den   <= cnt_inc;
          dcnt  <= 6'd32;
          ret   <= S_B_RATE;
          state <= S_DIV;
        end
        S_B_RATE: begin
          mean_rate[k] <= neg ? m_rate - dq : m_rate + dq;
          neg   <= pending_lma[bj[PIW-1:0]] < m_lma;
          dq    <= mag_l;
          rem   <= '0;
          den   <= cnt_cur;
          dcnt  <= 6'd32;
          ret   <= S_B_LMA;
          state <= S_DIV;
        end
        S_B_LMA: begin
          mean_lma[k] <= neg ? m_lma - dq : m_lma + dq;
          if (bj + FW'(1) == pending_fill) begin
            pending_fill <= '0;
            done_pend    <= 1'b1;
            state        <= S_IDLE;
          end else begin
            bj    <= bj + FW'(1);
            state <= S_B_SEL;
          end
        end
        S_DIV: begin
          if (!ddiff[32]) begin
            rem <= ddiff[31:0];
            dq  <= {dq[30:0], 1'b1};
          end else begin
            rem <= dsh[31:0];
            dq  <= {dq[30:0], 1'b0};
          end
          dcnt <= dcnt - 6'd1;
          if (dcnt == 6'd1) state <= ret;
        end
        default: state <= S_IDLE;
      endcase

      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_NUM_CLUSTERS: begin
            if (cfg_data[4:0] == 5'd0) nc <= 5'd1;
            else if (32'(cfg_data[4:0]) > MAX_CLUSTERS) nc <= 5'(MAX_CLUSTERS);
            else nc <= cfg_data[4:0];
            ci           <= '0;
            pending_fill <= '0;
            state        <= S_INIT_DIV;
          end
          REG_BATCH_LENGTH: begin
            if (cfg_data[3:0] == 4'd0) bl <= 4'd1;
            else if (32'(cfg_data[3:0]) > MAX_BATCH) bl <= 4'(MAX_BATCH);
            else bl <= cfg_data[3:0];
          end
          REG_NORM_RATE:   norm_rate <= cfg_data;
          REG_NORM_LMA:    norm_lma  <= cfg_data;
          REG_WEIGHT_RATE: wr        <= cfg_data[7:0];
          REG_WEIGHT_LMA:  wl        <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== sv/mkc_checker.sv =====
`include "minibatch_kmeans_classifier_unit_macros.svh"
module mkc_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_valid,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input logic [3:0]                    cluster_index
);
  import mkc_pkg::*;

  // held result beat
  `MKC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cluster_index))
  // one point in flight
  `MKC_ASSERT_NEXT(a_one_point, in_valid && in_ready, !in_ready)
  // reset starts the mean sweep
  `MKC_ASSERT_ALWAYS(a_reset_sweep, rst, !in_ready && !out_valid)
endmodule

bind minibatch_kmeans_classifier_unit mkc_checker u_mkc_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .cluster_index(cluster_index)
);

// ===== tb/minibatch_kmeans_classifier_unit_checker.sv =====
module minibatch_kmeans_classifier_unit_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [31:0]                   rate_raw,
  input  logic [31:0]                   lma_raw,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic [3:0]                    cluster_index,
  input  logic                          cfg_valid,
  input  logic                          cfg_ready,
  input  logic [mkc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mkc_pkg::DATA_W-1:0]    cfg_data,
  output int                            errors,
  output int                            outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import mkc_pkg::*;

  localparam int NCLUST = 16;
  localparam int NBATCH = 8;
  localparam int FRAC   = 16;

  bit [4:0]  k_clusters;
  bit [3:0]  k_batch;
  bit [31:0] k_norm_rate, k_norm_lma;
  bit [7:0]  k_w_rate, k_w_lma;

  bit [31:0] centroid_rate [NCLUST];
  bit [31:0] centroid_lma  [NCLUST];
  bit [31:0] members       [NCLUST];
  bit [31:0] buf_rate      [NBATCH];
  bit [31:0] buf_lma       [NBATCH];
  bit [3:0]  buf_cluster   [NBATCH];
  int        buf_fill;

  bit [3:0]  expected_index [$];

  initial errors = 0;
  assign outstanding = expected_index.size();

  task automatic report(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  function automatic void seed_centroids();
    bit [63:0] num;
    for (int i = 0; i < NCLUST; i++) begin
      num = 64'(i) << FRAC;
      centroid_rate[i] = 32'(num / k_clusters);
      centroid_lma[i]  = '0;
      members[i]       = '0;
    end
    buf_fill = 0;
  endfunction

  function automatic logic [72:0] weighted_square(bit [31:0] d, bit [7:0] w);
    logic [72:0] acc;
    acc = 73'(d);
    acc = acc * 73'(d);
    acc = acc * 73'(w);
    return acc;
  endfunction

  function automatic bit [31:0] nudge(bit [31:0] m, bit [31:0] x, bit [31:0] c);
    if (x >= m) begin
      return m + (x - m) / c;
    end
    return m - (m - x) / c;
  endfunction

  function automatic bit [31:0] adiff(bit [31:0] a, bit [31:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic bit [3:0] classify_point(bit [31:0] r, bit [31:0] l);
    bit [31:0]   xr, xl;
    logic [72:0] score, best;
    bit [3:0]    win;
    int          k;
    xr = r / ((k_norm_rate == 0) ? 32'd1 : k_norm_rate);
    xl = l / ((k_norm_lma == 0) ? 32'd1 : k_norm_lma);
    win = 0;
    best = '0;
    for (int i = 0; i < k_clusters; i++) begin
      score = weighted_square(adiff(xr, centroid_rate[i]), k_w_rate)
            + weighted_square(adiff(xl, centroid_lma[i]), k_w_lma);
      if (i == 0 || score < best) begin
        best = score;
        win = 4'(i);
      end
    end
    if (buf_fill < NBATCH) begin
      buf_rate[buf_fill]    = xr;
      buf_lma[buf_fill]     = xl;
      buf_cluster[buf_fill] = win;
      buf_fill++;
    end
    // buffer flush: every held point moves its centroid in arrival order
    if (buf_fill >= k_batch) begin
      for (int j = 0; j < buf_fill; j++) begin
        k = buf_cluster[j];
        if (members[k] != 32'hFFFF_FFFF) members[k]++;
        centroid_rate[k] = nudge(centroid_rate[k], buf_rate[j], members[k]);
        centroid_lma[k]  = nudge(centroid_lma[k], buf_lma[j], members[k]);
      end
      buf_fill = 0;
    end
    return win;
  endfunction

  function automatic void write_register(bit [2:0] idx, bit [31:0] data);
    case (idx)
      REG_NUM_CLUSTERS: begin
        k_clusters = (data[4:0] == 0) ? 5'd1 : (data[4:0] > NCLUST) ? 5'(NCLUST) : data[4:0];
        seed_centroids();
      end
      REG_BATCH_LENGTH: begin
        k_batch = (data[3:0] == 0) ? 4'd1 : (data[3:0] > NBATCH) ? 4'(NBATCH) : data[3:0];
      end
      REG_NORM_RATE:   k_norm_rate = data;
      REG_NORM_LMA:    k_norm_lma  = data;
      REG_WEIGHT_RATE: k_w_rate    = data[7:0];
      REG_WEIGHT_LMA:  k_w_lma     = data[7:0];
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      k_clusters  = 16;
      k_batch     = 6;
      k_norm_rate = 1;
      k_norm_lma  = 1;
      k_w_rate    = 10;
      k_w_lma     = 0;
      seed_centroids();
      expected_index.delete();
    end else begin
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (out_valid && out_ready) begin
        if (expected_index.size() == 0) begin
          report($sformatf("unexpected result beat, cluster_index %0d", cluster_index));
        end else begin
          if (cluster_index !== expected_index[0])
            report($sformatf("cluster_index %0d, expected %0d", cluster_index,
                             expected_index[0]));
          void'(expected_index.pop_front());
        end
      end
      if (in_valid && in_ready) expected_index.push_back(classify_point(rate_raw, lma_raw));
    end
  end
endmodule

// ===== tb/tb_minibatch_kmeans_classifier_unit.sv =====
module tb_minibatch_kmeans_classifier_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mkc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam int TOTAL_POINTS = 1450;
  localparam int SETTLE_CYCLES = 700;
  localparam int STALL_LIMIT = 10000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [31:0] rate_raw = '0;
  logic [31:0] lma_raw = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] cluster_index;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [DATA_W-1:0] cfg_data = '0;

  int errors, outstanding;
  int points_sent = 0;
  int reg_writes = 0;
  int send_idle_pct = 7;
  int recv_idle_pct = 51;
  int quiet_cycles = 0;
  bit [31:0] cur_norm_rate = 1, cur_norm_lma = 1;

  minibatch_kmeans_classifier_unit dut (.*);

  minibatch_kmeans_classifier_unit_checker checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_ready <= rst ? 1'b0 : ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat in %0d cycles", STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_point(input bit [31:0] r, input bit [31:0] l);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rate_raw <= r;
    lma_raw  <= l;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    points_sent++;
    if (points_sent == TOTAL_POINTS / 3) begin
      send_idle_pct = 51;
      recv_idle_pct = 7;
    end else if (points_sent == 2 * TOTAL_POINTS / 3) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // leaves cfg_valid high so back-to-back writes need no extra edge
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input bit [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    reg_writes++;
    if (idx == REG_NORM_RATE) cur_norm_rate = data;
    if (idx == REG_NORM_LMA) cur_norm_lma = data;
  endtask

  // block must be idle, batch update included, before touching registers
  task automatic settle();
    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic bit [31:0] pick_norm();
    case ($urandom_range(0, 9))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3, 4, 5, 6: return (32'd1 << $urandom_range(8, 16)) + $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  // mostly lands near the Q16.16 centroid range once normalized
  function automatic bit [31:0] pick_raw(bit [31:0] norm);
    bit [63:0] eff, raw;
    eff = (norm <= 1) ? 64'd1 : 64'(norm);
    if ($urandom_range(0, 99) < 15) return $urandom;
    raw = 64'($urandom_range(0, 32'h1FFFF)) * eff + 64'($urandom_range(0, 32'(eff - 1)));
    return (raw > 64'hFFFF_FFFF) ? $urandom : raw[31:0];
  endfunction

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // reset settings: centroids at i/16, only rate weighted
    send_point(32'h0, 32'h0);
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'h0, 32'hFFFF_FFFF);
    send_point(32'hFFFF_FFFF, 32'h0);
    send_point(32'd2048, 32'h5555_5555);
    send_point(32'd12288, 32'hAAAA_AAAA);
    send_point(32'd61440, 32'h1);
    send_point(32'd63488, 32'h8000_0000);
    send_point(32'h0001_0000, 32'h0);
    send_point(32'h8000_0000, 32'h7FFF_FFFF);

    // no weights at all: every score ties
    settle();
    cfg_write(REG_WEIGHT_RATE, 32'd0);
    cfg_write(REG_WEIGHT_LMA, 32'd0);
    cfg_write(REG_BATCH_LENGTH, 32'd8);
    cfg_write(REG_SPARE_LO, 32'hFFFF_FFFF);
    cfg_write(REG_SPARE_HI, 32'h0);
    cfg_valid <= 1'b0;
    send_point(32'h1234_5678, 32'h9ABC_DEF0);
    send_point(32'hFFFF_FFFF, 32'h0);
    send_point(32'd40000, 32'd40000);

    // zero clamps to one everywhere
    settle();
    cfg_write(REG_NUM_CLUSTERS, 32'd0);
    cfg_write(REG_BATCH_LENGTH, 32'd0);
    cfg_write(REG_NORM_RATE, 32'd0);
    cfg_write(REG_NORM_LMA, 32'd0);
    cfg_write(REG_WEIGHT_RATE, 32'd255);
    cfg_write(REG_WEIGHT_LMA, 32'd255);
    cfg_valid <= 1'b0;
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'h0, 32'h0);
    send_point(32'hFFFF_FFFF, 32'h0);

    // oversized values saturate; full-scale normalizers
    settle();
    cfg_write(REG_NUM_CLUSTERS, 32'd31);
    cfg_write(REG_BATCH_LENGTH, 32'd15);
    cfg_write(REG_NORM_RATE, 32'hFFFF_FFFF);
    cfg_write(REG_NORM_LMA, 32'hFFFF_FFFF);
    cfg_write(REG_WEIGHT_LMA, 32'd0);
    cfg_valid <= 1'b0;
    send_point(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_point(32'hFFFF_FFFE, 32'h0);
    send_point(32'h0, 32'hFFFF_FFFF);

    while (points_sent < TOTAL_POINTS) begin
      settle();
      if ($urandom_range(0, 1)) begin
        cfg_write(REG_NUM_CLUSTERS, ($urandom_range(0, 9) == 0) ? $urandom
                                    : $urandom_range(1, 16));
      end
      // writing batch_length while points are held exercises early flush
      cfg_write(REG_BATCH_LENGTH, ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(1, 8));
      cfg_write(REG_NORM_RATE, pick_norm());
      cfg_write(REG_NORM_LMA, pick_norm());
      cfg_write(REG_WEIGHT_RATE, ($urandom_range(0, 4) == 0) ? 32'd255 : $urandom_range(0, 255));
      cfg_write(REG_WEIGHT_LMA, ($urandom_range(0, 4) == 0) ? 32'd0 : $urandom);
      if ($urandom_range(0, 9) == 0) cfg_write(REG_SPARE_HI, $urandom);
      cfg_valid <= 1'b0;
      repeat ($urandom_range(20, 80)) begin
        send_point(pick_raw(cur_norm_rate), pick_raw(cur_norm_lma));
      end
    end

    in_valid <= 1'b0;
    cfg_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Classified %0d points across %0d register writes, with sender/receiver",
             points_sent, reg_writes);
    $display("stalls, tied scores, clamped settings and batch flushes of every length.");
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+sv
sv/mkc_pkg.sv
sv/minibatch_kmeans_classifier_unit.sv
sv/mkc_checker.sv
tb/minibatch_kmeans_classifier_unit_checker.sv
tb/tb_minibatch_kmeans_classifier_unit.sv
